// ===== design/upg_pkg.sv =====
// Shared request codes and field widths for the unique permutation generator.
`timescale 1ns / 1ps
`default_nettype none

package upg_pkg;

	localparam int REQ_W = 2;
	localparam int VAL_W = 32;
	localparam int POS_W = 4;

	typedef logic [REQ_W-1:0]        req_code_t;
	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [POS_W-1:0]        pos_t;

	localparam req_code_t REQ_CLEAR = 2'd0;
	localparam req_code_t REQ_LOAD  = 2'd1;
	localparam req_code_t REQ_NEXT  = 2'd2;

endpackage

`default_nettype wire

// ===== design/upg_if.sv =====
// Request and result channel interfaces of the unique permutation generator.
`timescale 1ns / 1ps
`default_nettype none

interface upg_req_if;
	import upg_pkg::*;

	logic      valid;
	logic      ready;
	req_code_t req_type;
	value_t    value;

	modport source (output valid, output req_type, output value, input ready);
	modport sink (input valid, input req_type, input value, output ready);
endinterface

interface upg_res_if;
	import upg_pkg::*;

	logic   valid;
	logic   ready;
	value_t value_res;
	pos_t   position;
	logic   last;
	logic   exhausted;

	modport source (output valid, output value_res, output position, output last,
		output exhausted, input ready);
	modport sink (input valid, input value_res, input position, input last,
		input exhausted, output ready);
endinterface

`default_nettype wire

// ===== design/unique_permutation_generator.sv =====
// Top level: multiset store and next-distinct-permutation sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Loads insert one signed element into a sorted store; each next request sends
// the next distinct lexicographic permutation, one result transfer per element
// (position counts from zero, last marks the final one), or a single exhausted
// result once all permutations are used or the set is empty. A load shifts each
// stored element larger than the new one up by one place, reading the sorted
// store from the end through its single registered read port, then writes the
// new element. The first next request after a load streams the sorted order
// and copies it into the working store. A later one runs over the working
// store: pivot scan from the end, successor scan, swap, reversal of the suffix
// pair by pair, then it sends each element. A new request is taken once the
// last element of the previous one sits in the output register.
module unique_permutation_generator #(
	parameter int MAX_ELEMS  = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	upg_req_if.sink     req,
	upg_res_if.source   res
);
	import upg_pkg::*;

	localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
	localparam int CW = $clog2(MAX_ELEMS + 1);
	localparam int XW = (ELEM_WIDTH > VAL_W) ? ELEM_WIDTH : VAL_W;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_INS_RD  = 4'd1;
	localparam logic [3:0] ST_INS_CMP = 4'd2;
	localparam logic [3:0] ST_EXH     = 4'd3;
	localparam logic [3:0] ST_EMIT_RD = 4'd4;
	localparam logic [3:0] ST_EMIT_WR = 4'd5;
	localparam logic [3:0] ST_PIV_RD  = 4'd6;
	localparam logic [3:0] ST_PIV_CMP = 4'd7;
	localparam logic [3:0] ST_SUC_RD  = 4'd8;
	localparam logic [3:0] ST_SUC_CMP = 4'd9;
	localparam logic [3:0] ST_SWAP_W1 = 4'd10;
	localparam logic [3:0] ST_SWAP_W2 = 4'd11;
	localparam logic [3:0] ST_REV_RD  = 4'd12;
	localparam logic [3:0] ST_REV_W1  = 4'd13;
	localparam logic [3:0] ST_REV_W2  = 4'd14;

	typedef logic signed [ELEM_WIDTH-1:0] elem_t;

	// Control state
	logic [3:0]    state_q;
	logic [CW-1:0] count_q;
	logic          started_q;
	logic          finished_q;
	logic          src_work_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] hi_q;
	logic [IW-1:0] piv_q;
	elem_t         pv_q;
	elem_t         tmp_q;
	elem_t         ins_val_q;

	// Output register
	logic   out_valid_q;
	value_t out_value_q;
	pos_t   out_pos_q;
	logic   out_last_q;
	logic   out_exh_q;

	// Sorted store: one read, one write
	elem_t         s_mem [MAX_ELEMS];
	elem_t         s_rdata;
	logic          s_we;
	logic [IW-1:0] s_waddr;
	logic [IW-1:0] s_raddr;
	elem_t         s_wdata;

	// Working store: two reads, one write
	elem_t         w_mem [MAX_ELEMS];
	elem_t         w_rdata_a;
	elem_t         w_rdata_b;
	logic          w_we;
	logic [IW-1:0] w_waddr;
	logic [IW-1:0] w_raddr_a;
	logic [IW-1:0] w_raddr_b;
	elem_t         w_wdata;

	logic          req_xfer;
	logic          out_free;
	logic          emit_go;
	logic          exh_go;
	logic          ins_less;
	logic [IW-1:0] n_last;
	logic          emit_last;
	elem_t         emit_val;
	logic signed [XW-1:0] emit_ext;

	assign req.ready  = (state_q == ST_IDLE);
	assign req_xfer   = req.valid && req.ready;
	assign out_free   = !out_valid_q || res.ready;
	assign emit_go    = (state_q == ST_EMIT_WR) && out_free;
	assign exh_go     = (state_q == ST_EXH) && out_free;
	assign ins_less   = ins_val_q < s_rdata;
	assign n_last     = IW'(count_q - 1'b1);
	assign emit_last  = (idx_q == n_last);
	assign emit_val   = src_work_q ? w_rdata_a : s_rdata;
	assign emit_ext   = XW'(emit_val);

	assign res.valid     = out_valid_q;
	assign res.value_res = out_value_q;
	assign res.position  = out_pos_q;
	assign res.last      = out_last_q;
	assign res.exhausted = out_exh_q;

	// Steer sorted store accesses
	always_comb begin
		s_raddr = (state_q == ST_INS_RD) ? idx_q - 1'b1 : idx_q;
		s_we    = ((state_q == ST_INS_RD) && (idx_q == '0)) || (state_q == ST_INS_CMP);
		s_waddr = idx_q;
		s_wdata = ((state_q == ST_INS_CMP) && ins_less) ? s_rdata : ins_val_q;
	end

	// Steer working store accesses
	always_comb begin
		w_raddr_a = idx_q;
		w_raddr_b = hi_q;
		w_we      = 1'b0;
		w_waddr   = idx_q;
		w_wdata   = s_rdata;
		case (state_q)
			ST_PIV_RD: begin
				w_raddr_a = idx_q - 1'b1;
				w_raddr_b = idx_q;
			end
			ST_EMIT_WR: begin
				w_we = emit_go && !src_work_q;
			end
			ST_SWAP_W1: begin
				w_we    = 1'b1;
				w_waddr = piv_q;
				w_wdata = tmp_q;
			end
			ST_SWAP_W2: begin
				w_we    = 1'b1;
				w_wdata = pv_q;
			end
			ST_REV_W1: begin
				w_we    = 1'b1;
				w_wdata = w_rdata_b;
			end
			ST_REV_W2: begin
				w_we    = 1'b1;
				w_waddr = hi_q;
				w_wdata = tmp_q;
			end
			default: begin
			end
		endcase
	end

	// Sorted store
	always_ff @(posedge clk) begin
		if (s_we) begin
			s_mem[s_waddr] <= s_wdata;
		end
		s_rdata <= s_mem[s_raddr];
	end

	// Working store
	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_waddr] <= w_wdata;
		end
		w_rdata_a <= w_mem[w_raddr_a];
		w_rdata_b <= w_mem[w_raddr_b];
	end

	// Sequence requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			started_q  <= 1'b0;
			finished_q <= 1'b0;
			src_work_q <= 1'b0;
			idx_q      <= '0;
			hi_q       <= '0;
			piv_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						case (req.req_type)
							REQ_CLEAR: begin
								count_q    <= '0;
								started_q  <= 1'b0;
								finished_q <= 1'b0;
							end
							REQ_LOAD: begin
								if (count_q != CW'(MAX_ELEMS)) begin
									idx_q      <= IW'(count_q);
									started_q  <= 1'b0;
									finished_q <= 1'b0;
									state_q    <= ST_INS_RD;
								end
							end
							REQ_NEXT: begin
								if (count_q == '0 || finished_q) begin
									state_q <= ST_EXH;
								end else if (!started_q) begin
									started_q  <= 1'b1;
									src_work_q <= 1'b0;
									idx_q      <= '0;
									state_q    <= ST_EMIT_RD;
								end else if (count_q == CW'(1)) begin
									finished_q <= 1'b1;
									state_q    <= ST_EXH;
								end else begin
									idx_q   <= n_last;
									state_q <= ST_PIV_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_INS_RD: begin
					if (idx_q == '0) begin
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (ins_less) begin
						idx_q   <= idx_q - 1'b1;
						state_q <= ST_INS_RD;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_EXH: begin
					if (exh_go) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (emit_go) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_PIV_RD: begin
					state_q <= ST_PIV_CMP;
				end
				ST_PIV_CMP: begin
					if (w_rdata_a < w_rdata_b) begin
						piv_q   <= idx_q - 1'b1;
						idx_q   <= n_last;
						state_q <= ST_SUC_RD;
					end else if (idx_q == IW'(1)) begin
						finished_q <= 1'b1;
						state_q    <= ST_EXH;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= ST_PIV_RD;
					end
				end
				ST_SUC_RD: begin
					state_q <= ST_SUC_CMP;
				end
				ST_SUC_CMP: begin
					if (pv_q < w_rdata_a) begin
						state_q <= ST_SWAP_W1;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= ST_SUC_RD;
					end
				end
				ST_SWAP_W1: begin
					state_q <= ST_SWAP_W2;
				end
				ST_SWAP_W2: begin
					idx_q   <= piv_q + 1'b1;
					hi_q    <= n_last;
					state_q <= ST_REV_RD;
				end
				ST_REV_RD: begin
					if (idx_q < hi_q) begin
						state_q <= ST_REV_W1;
					end else begin
						src_work_q <= 1'b1;
						idx_q      <= '0;
						state_q    <= ST_EMIT_RD;
					end
				end
				ST_REV_W1: begin
					state_q <= ST_REV_W2;
				end
				ST_REV_W2: begin
					idx_q   <= idx_q + 1'b1;
					hi_q    <= hi_q - 1'b1;
					state_q <= ST_REV_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold operand values for insert, pivot and swap
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			ins_val_q <= ELEM_WIDTH'(req.value);
		end
		if ((state_q == ST_PIV_CMP) && (w_rdata_a < w_rdata_b)) begin
			pv_q <= w_rdata_a;
		end
		if ((state_q == ST_SUC_CMP) || (state_q == ST_REV_W1)) begin
			tmp_q <= w_rdata_a;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go || exh_go) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_value_q <= emit_ext[VAL_W-1:0];
			out_pos_q   <= POS_W'(idx_q);
			out_last_q  <= emit_last;
			out_exh_q   <= 1'b0;
		end else if (exh_go) begin
			out_value_q <= '0;
			out_pos_q   <= '0;
			out_last_q  <= 1'b1;
			out_exh_q   <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== design/upg_chk.sv =====
// Port-level assertions for the unique permutation generator and their bind.
`timescale 1ns / 1ps
`default_nettype none

module upg_chk (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  req_valid,
	input wire logic                  req_ready,
	input wire upg_pkg::req_code_t    req_type,
	input wire logic                  res_valid,
	input wire logic                  res_ready,
	input wire upg_pkg::value_t       value_res,
	input wire upg_pkg::pos_t         position,
	input wire logic                  last,
	input wire logic                  exhausted
);
	import upg_pkg::*;

	// An exhausted result is a lone, zeroed, last transfer
	a_exh_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && exhausted |-> last && position == '0 && value_res == '0)
		else $error("exhausted result not zeroed or not marked last");

	// A clear or load never produces a result of its own
	a_no_result_on_setup: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_CLEAR || req_type == REQ_LOAD)
		|=> !res_valid || $past(res_valid && !res_ready))
		else $error("result produced by clear or load");

	// A stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value_res)
		&& $stable(position) && $stable(last) && $stable(exhausted))
		else $error("stalled result changed");

	// Positions advance by one within a permutation
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last ##1 res_valid
		|-> position == $past(position) + 1'b1 || $past(res_valid && res_ready) == 1'b0)
		else $error("element position out of order");

endmodule

bind unique_permutation_generator upg_chk u_upg_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.value_res (res.value_res),
	.position  (res.position),
	.last      (res.last),
	.exhausted (res.exhausted)
);

`default_nettype wire
